[hdl/pfpa_pkg.sv]
// Shared types and constants of the polygon fan primitive assembler.
// Holds the queue word layout, the run codes and the result kinds.
// No dependencies.
package pfpa_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // Result kinds.
    localparam logic [1:0] KIND_TRI    = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_SPRITE = 2'd2;

    localparam logic [23:0] WHITE = 24'hFFFFFF;

    // Run codes: what one vertex word turns into.
    localparam logic [2:0] OP_EDGE   = 3'd0; // line prev -> cur
    localparam logic [2:0] OP_CLOSE  = 3'd1; // line cur -> first
    localparam logic [2:0] OP_BOTH   = 3'd2; // edge, then closing line
    localparam logic [2:0] OP_TRI    = 3'd3; // fan triangle first, prev, cur
    localparam logic [2:0] OP_SPRITE = 3'd4; // sprite on cur

    // Vertex slots held in a queue word.
    localparam logic [1:0] SRC_FIRST = 2'd0;
    localparam logic [1:0] SRC_PREV  = 2'd1;
    localparam logic [1:0] SRC_CUR   = 2'd2;

    // One queued run: positions are {x,y,z}, texture coordinates {u,v}.
    typedef struct packed {
        logic [2:0]        op;
        logic [2:0][47:0]  pos;
        logic [2:0][31:0]  uv;
        logic [23:0]       rgb;
        logic              tex;
        logic [31:0]       handle;
        logic [15:0]       size;
    } t_entry;

    // Handshake between the front and the queue.
    typedef struct packed {
        logic push;
    } t_front_ctl;

    typedef struct packed {
        logic full;
    } t_queue_sts;

endpackage

[hdl/pfpa_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pfpa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/pfpa_front.sv]
// Front of the assembler: accepts words, loads and reads the palette, tracks
// the face state and classifies each vertex into a queued run.
// Depends on pfpa_pkg and pfpa_ram.
module pfpa_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_func,
    input  logic [31:0]             i_desc1,
    input  logic [31:0]             i_pal_word,
    input  logic                    i_face_wireframe,
    input  logic                    i_face_textured,
    input  logic [15:0]             i_sprite_desc,
    input  logic signed [15:0]      i_vert_x,
    input  logic signed [15:0]      i_vert_y,
    input  logic signed [15:0]      i_vert_z,
    input  logic signed [15:0]      i_vert_u,
    input  logic signed [15:0]      i_vert_v,
    input  logic                    i_last_vertex,
    input  pfpa_pkg::t_queue_sts    i_q_sts,
    output pfpa_pkg::t_front_ctl    o_ctl,
    output pfpa_pkg::t_entry        o_entry
);
    import pfpa_pkg::*;

    logic [2:0]       r_count, n_count;
    logic [47:0]      r_first_pos;
    logic [31:0]      r_first_uv;
    logic [47:0]      r_prev_pos;
    logic [31:0]      r_prev_uv;
    logic [2:0][31:0] r_held;
    logic             r_s1_valid;
    logic             r_s1_ci_ok;
    t_entry           r_s1;
    t_entry           n_s1;

    logic        accept, vtx, load_we, s1_free, has_res, ci_ok;
    logic [47:0] cur_pos, first_pos;
    logic [31:0] cur_uv, first_uv;
    logic [2:0]  op;
    logic [31:0] pal_rdata;

    assign s1_free    = !r_s1_valid || !i_q_sts.full;
    assign o_in_ready = s1_free;
    assign accept     = i_in_valid && s1_free;
    assign vtx        = accept && i_func;
    assign load_we    = accept && !i_func && (i_desc1 < 32'(PALETTE_ENTRIES));
    assign ci_ok      = (32'(i_desc1[7:0]) < 32'(PALETTE_ENTRIES));

    pfpa_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_desc1[PAL_AW-1:0]),
        .i_wdata (i_pal_word),
        .i_re    (vtx),
        .i_raddr (i_desc1[PAL_AW-1:0]),
        .o_rdata (pal_rdata)
    );

    assign cur_pos   = {i_vert_x, i_vert_y, i_vert_z};
    assign cur_uv    = {i_vert_u, i_vert_v};
    assign first_pos = (r_count == 3'd0) ? cur_pos : r_first_pos;
    assign first_uv  = (r_count == 3'd0) ? cur_uv : r_first_uv;

    // Classify the vertex by face mode, position in the face and the close flag.
    always_comb begin
        op      = OP_EDGE;
        has_res = 1'b0;
        if (i_face_wireframe) begin
            if (r_count != 3'd0 && i_last_vertex) begin
                op      = OP_BOTH;
                has_res = 1'b1;
            end else if (r_count != 3'd0) begin
                op      = OP_EDGE;
                has_res = 1'b1;
            end else if (i_last_vertex) begin
                op      = OP_CLOSE;
                has_res = 1'b1;
            end
        end else begin
            if (r_count >= 3'd2) begin
                op      = OP_TRI;
                has_res = 1'b1;
            end else if (i_last_vertex && r_count == 3'd1) begin
                op      = OP_EDGE;
                has_res = 1'b1;
            end else if (i_last_vertex && i_face_textured) begin
                op      = OP_SPRITE;
                has_res = 1'b1;
            end
        end
    end

    always_comb begin
        n_s1        = r_s1;
        n_s1.op     = op;
        n_s1.pos[SRC_FIRST] = first_pos;
        n_s1.pos[SRC_PREV]  = r_prev_pos;
        n_s1.pos[SRC_CUR]   = cur_pos;
        n_s1.uv     = '0;
        n_s1.rgb    = '0;
        n_s1.tex    = 1'b0;
        n_s1.handle = '0;
        n_s1.size   = '0;
        if (op == OP_TRI && i_face_textured) begin
            n_s1.tex    = 1'b1;
            n_s1.handle = i_desc1;
            if (r_count < 3'd4) begin
                n_s1.uv[SRC_FIRST] = first_uv;
                n_s1.uv[SRC_PREV]  = r_prev_uv;
                n_s1.uv[SRC_CUR]   = cur_uv;
            end else begin
                n_s1.uv = r_held;
            end
        end else if (op == OP_SPRITE) begin
            n_s1.tex    = 1'b1;
            n_s1.handle = i_desc1;
            n_s1.size   = i_sprite_desc;
        end
    end

    always_comb begin
        if (i_last_vertex) begin
            n_count = 3'd0;
        end else if (r_count < 3'd4) begin
            n_count = r_count + 3'd1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_first_pos <= '0;
            r_first_uv  <= '0;
            r_prev_pos  <= '0;
            r_prev_uv   <= '0;
            r_held      <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (vtx) begin
                r_count     <= n_count;
                r_first_pos <= first_pos;
                r_first_uv  <= first_uv;
                r_prev_pos  <= cur_pos;
                r_prev_uv   <= cur_uv;
                if (!i_face_wireframe && r_count == 3'd3) begin
                    r_held[SRC_FIRST] <= first_uv;
                    r_held[SRC_PREV]  <= r_prev_uv;
                    r_held[SRC_CUR]   <= cur_uv;
                end
            end
            if (s1_free) begin
                r_s1_valid <= vtx && has_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && vtx) begin
            r_s1       <= n_s1;
            r_s1_ci_ok <= ci_ok;
        end
    end

    // Colour is resolved here, where the palette read data has arrived.
    always_comb begin
        o_entry = r_s1;
        if (r_s1.tex) begin
            o_entry.rgb = WHITE;
        end else if (r_s1_ci_ok) begin
            o_entry.rgb = pal_rdata[31:8];
        end else begin
            o_entry.rgb = '0;
        end
    end

    assign o_ctl.push = r_s1_valid && !i_q_sts.full;

endmodule

[hdl/pfpa_queue.sv]
// Two-entry queue of classified runs between the front and the back.
// Depends on pfpa_pkg.
module pfpa_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfpa_pkg::t_front_ctl  i_ctl,
    input  pfpa_pkg::t_entry      i_entry,
    output pfpa_pkg::t_queue_sts  o_sts,
    input  logic                  i_pop,
    output logic                  o_head_valid,
    output pfpa_pkg::t_entry      o_head
);
    import pfpa_pkg::*;

    t_entry     r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_sts.full   = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_ctl.push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

endmodule

[hdl/pfpa_back.sv]
// Back of the assembler: walks one queued run into the output register, a result
// per cycle while the output is not stalled. Depends on pfpa_pkg.
module pfpa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  pfpa_pkg::t_entry  i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_prim_kind,
    output logic [23:0]       o_colour_rgb,
    output logic              o_tex_enable,
    output logic [31:0]       o_texture_handle,
    output logic [15:0]       o_sprite_size,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic signed [15:0] o_out_u,
    output logic signed [15:0] o_out_v,
    output logic              o_last_of_primitive,
    output logic              o_last_of_run
);
    import pfpa_pkg::*;

    logic [1:0]  r_step;
    logic        r_valid;
    logic [1:0]  step_end, src, kind;
    logic        lp, load;
    logic [47:0] pos;
    logic [31:0] uv;

    always_comb begin
        step_end = 2'd0;
        src      = SRC_CUR;
        kind     = KIND_LINE;
        lp       = 1'b0;
        case (i_head.op)
            OP_EDGE: begin
                step_end = 2'd1;
                src      = (r_step == 2'd0) ? SRC_PREV : SRC_CUR;
                lp       = (r_step == 2'd1);
            end
            OP_CLOSE: begin
                step_end = 2'd1;
                src      = (r_step == 2'd0) ? SRC_CUR : SRC_FIRST;
                lp       = (r_step == 2'd1);
            end
            OP_BOTH: begin
                step_end = 2'd3;
                lp       = r_step[0];
                case (r_step)
                    2'd0:    src = SRC_PREV;
                    2'd3:    src = SRC_FIRST;
                    default: src = SRC_CUR;
                endcase
            end
            OP_TRI: begin
                step_end = 2'd2;
                kind     = KIND_TRI;
                lp       = (r_step == 2'd2);
                case (r_step)
                    2'd0:    src = SRC_FIRST;
                    2'd1:    src = SRC_PREV;
                    default: src = SRC_CUR;
                endcase
            end
            OP_SPRITE: begin
                step_end = 2'd0;
                kind     = KIND_SPRITE;
                lp       = 1'b1;
            end
            default: begin
                step_end = 2'd0;
            end
        endcase
    end

    always_comb begin
        case (src)
            SRC_FIRST: begin
                pos = i_head.pos[SRC_FIRST];
                uv  = i_head.uv[SRC_FIRST];
            end
            SRC_PREV: begin
                pos = i_head.pos[SRC_PREV];
                uv  = i_head.uv[SRC_PREV];
            end
            default: begin
                pos = i_head.pos[SRC_CUR];
                uv  = i_head.uv[SRC_CUR];
            end
        endcase
    end

    assign load  = i_head_valid && (!r_valid || i_out_ready);
    assign o_pop = load && (r_step == step_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step <= (r_step == step_end) ? 2'd0 : r_step + 2'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_prim_kind         <= kind;
            o_colour_rgb        <= i_head.rgb;
            o_tex_enable        <= i_head.tex;
            o_texture_handle    <= i_head.handle;
            o_sprite_size       <= i_head.size;
            o_out_x             <= pos[47:32];
            o_out_y             <= pos[31:16];
            o_out_z             <= pos[15:0];
            o_out_u             <= uv[31:16];
            o_out_v             <= uv[15:0];
            o_last_of_primitive <= lp;
            o_last_of_run       <= (r_step == step_end);
        end
    end

    assign o_out_valid = r_valid;

endmodule

[hdl/polygon_fan_primitive_assembler_core.sv]
// Top level of the polygon fan primitive assembler: front, run queue, back.
// Depends on pfpa_pkg, pfpa_front, pfpa_queue and pfpa_back.
//
//   Channel   Valid / ready              Payload
//   input     i_in_valid / o_in_ready    i_func .. i_last_vertex
//   output    o_out_valid / i_out_ready  o_prim_kind .. o_last_of_run
//
// A palette load word is taken and yields no result. A vertex word goes
// through one front stage (the palette read) and then waits in a two-entry
// queue; the back issues one result word per cycle while the output is not
// stalled, and a word yields one result for a sprite, two for a line, three
// for a fan triangle and four for a closing wireframe edge. Reset is
// synchronous and active low; it clears the face state and all valid flags,
// while the palette holds garbage until loaded. The input side stalls only
// when the front stage holds a word and the queue is full.
module polygon_fan_primitive_assembler_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [31:0]        i_desc1,
    input  logic [31:0]        i_pal_word,
    input  logic               i_face_wireframe,
    input  logic               i_face_textured,
    input  logic [15:0]        i_sprite_desc,
    input  logic signed [15:0] i_vert_x,
    input  logic signed [15:0] i_vert_y,
    input  logic signed [15:0] i_vert_z,
    input  logic signed [15:0] i_vert_u,
    input  logic signed [15:0] i_vert_v,
    input  logic               i_last_vertex,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_prim_kind,
    output logic [23:0]        o_colour_rgb,
    output logic               o_tex_enable,
    output logic [31:0]        o_texture_handle,
    output logic [15:0]        o_sprite_size,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic signed [15:0] o_out_u,
    output logic signed [15:0] o_out_v,
    output logic               o_last_of_primitive,
    output logic               o_last_of_run
);
    import pfpa_pkg::*;

    t_front_ctl front_ctl;
    t_queue_sts queue_sts;
    t_entry     front_entry;
    t_entry     head;
    logic       head_valid;
    logic       pop;

    // The front owns the palette and the per-face vertex history, so a
    // palette load that follows a vertex can never change that vertex's colour.
    pfpa_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_desc1          (i_desc1),
        .i_pal_word       (i_pal_word),
        .i_face_wireframe (i_face_wireframe),
        .i_face_textured  (i_face_textured),
        .i_sprite_desc    (i_sprite_desc),
        .i_vert_x         (i_vert_x),
        .i_vert_y         (i_vert_y),
        .i_vert_z         (i_vert_z),
        .i_vert_u         (i_vert_u),
        .i_vert_v         (i_vert_v),
        .i_last_vertex    (i_last_vertex),
        .i_q_sts          (queue_sts),
        .o_ctl            (front_ctl),
        .o_entry          (front_entry)
    );

    // The queue decouples the two sides: each run word carries everything
    // the back needs, fully resolved.
    pfpa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (front_ctl),
        .i_entry      (front_entry),
        .o_sts        (queue_sts),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // The back steps through the run and feeds the output register, which
    // holds its result under stall while the back stops popping the queue.
    pfpa_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head_valid        (head_valid),
        .i_head              (head),
        .o_pop               (pop),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_prim_kind         (o_prim_kind),
        .o_colour_rgb        (o_colour_rgb),
        .o_tex_enable        (o_tex_enable),
        .o_texture_handle    (o_texture_handle),
        .o_sprite_size       (o_sprite_size),
        .o_out_x             (o_out_x),
        .o_out_y             (o_out_y),
        .o_out_z             (o_out_z),
        .o_out_u             (o_out_u),
        .o_out_v             (o_out_v),
        .o_last_of_primitive (o_last_of_primitive),
        .o_last_of_run       (o_last_of_run)
    );

`ifndef SYNTHESIS
    // A run always ends on the closing vertex of a primitive.
    a_run_ends_prim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_run |-> o_last_of_primitive)
        else $error("run ended inside a primitive");

    // Sprites are always textured and white.
    a_sprite_tex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_prim_kind == KIND_SPRITE |-> o_tex_enable && o_colour_rgb == WHITE)
        else $error("sprite without texture");

    // Lines never carry texture data.
    a_line_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_prim_kind == KIND_LINE
        |-> !o_tex_enable && o_texture_handle == '0 && o_out_u == '0 && o_out_v == '0)
        else $error("textured line");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_ctl.push |-> !queue_sts.full)
        else $error("queue overflow");
`endif

endmodule
